@@ hdl/gda_pkg.sv @@
// Shared types and constants for the Gregorian date adder.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package gda_pkg;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W = 5;
  localparam int unsigned ADD_W = 15;
  localparam int unsigned REM_W = 17;

  // Month codes that the logic tests by name.
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Leap cycle: the year is reduced modulo 400 once, then tracked.
  localparam logic [YEAR_W-1:0] CYCLE_LEN = 14'd400;
  localparam logic [YEAR_W-1:0] CYCLE_LAST = 14'd399;
  localparam logic [YEAR_W-1:0] CENT_1 = 14'd100;
  localparam logic [YEAR_W-1:0] CENT_2 = 14'd200;
  localparam logic [YEAR_W-1:0] CENT_3 = 14'd300;
  // Highest shift of 400 that still fits under the largest 14-bit year.
  localparam logic [2:0] MOD_SHIFT_TOP = 3'd5;

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [ADD_W-1:0]   days_to_add;
  } gda_in_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic               error;
  } gda_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic mod_step;
    logic sum_step;
    logic walk_init;
    logic walk_step;
    logic out_load;
  } gda_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic month_bad;
    logic mod_last;
    logic sum_done;
    logic walk_fit;
  } gda_status_t;

  // Length of a month in days, given whether the year is a leap year.
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                               input logic leap);
    logic [DAY_W-1:0] len;
    case (month) inside
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ hdl/gda_ctrl.sv @@
// Controller state machine of the Gregorian date adder.
// Sequences year reduction, month sum and month walk; uses gda_pkg.
`default_nettype none

module gda_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire gda_pkg::gda_status_t status,
  output gda_pkg::gda_cmd_t         cmd
);
  import gda_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    REDUCE,
    SUM,
    WALK,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != IDLE);

  // Commands follow from the state and the datapath status.
  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = REDUCE;
        end
      end
      REDUCE: begin
        if (status.month_bad) begin
          state_next = FINISH;
        end else begin
          cmd.mod_step = 1'b1;
          if (status.mod_last) begin
            state_next = SUM;
          end
        end
      end
      SUM: begin
        if (status.sum_done) begin
          cmd.walk_init = 1'b1;
          state_next = WALK;
        end else begin
          cmd.sum_step = 1'b1;
        end
      end
      WALK: begin
        if (status.walk_fit) begin
          state_next = FINISH;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // State and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/gda_datapath.sv @@
// Datapath of the Gregorian date adder: day remainder, month, year and
// leap-cycle position registers, plus the result register; uses gda_pkg.
`default_nettype none

module gda_datapath (
  input  wire logic                clk,
  input  wire gda_pkg::gda_in_t    in_data,
  input  wire gda_pkg::gda_cmd_t   cmd,
  output gda_pkg::gda_status_t     status,
  output gda_pkg::gda_out_t        out_data
);
  import gda_pkg::*;

  gda_in_t            start;
  logic [REM_W-1:0]   rem;
  logic [MONTH_W-1:0] month;
  logic [YEAR_W:0]    year;
  logic [YEAR_W-1:0]  ymod;
  logic [2:0]         mod_shift;

  logic [YEAR_W-1:0]  mod_sub;
  logic               leap;
  logic [DAY_W-1:0]   len;
  logic               bad;

  // Year position within the 400-year cycle gives the leap rule.
  assign leap = (ymod == '0) ||
                ((ymod[1:0] == 2'b00) && (ymod != CENT_1) && (ymod != CENT_2) &&
                 (ymod != CENT_3));
  assign len = days_in(month, leap);
  assign mod_sub = CYCLE_LEN << mod_shift;

  assign status.month_bad = (start.start_month < MONTH_JAN) ||
                            (start.start_month > MONTH_DEC);
  assign status.mod_last = (mod_shift == '0);
  assign status.sum_done = (month == start.start_month);
  assign status.walk_fit = (rem <= REM_W'(len));

  assign bad = status.month_bad || year[YEAR_W];

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start <= in_data;
      rem <= REM_W'(in_data.start_day) + REM_W'(in_data.days_to_add);
      month <= MONTH_JAN;
      year <= (YEAR_W+1)'(in_data.start_year);
      ymod <= in_data.start_year;
      mod_shift <= MOD_SHIFT_TOP;
    end
    // One restoring step of the year modulo 400.
    if (cmd.mod_step) begin
      if (ymod >= mod_sub) begin
        ymod <= ymod - mod_sub;
      end
      mod_shift <= mod_shift - 3'd1;
    end
    // Add the length of each month before the start month.
    if (cmd.sum_step) begin
      rem <= rem + REM_W'(len);
      month <= month + 4'd1;
    end
    if (cmd.walk_init) begin
      month <= MONTH_JAN;
    end
    // Step past one whole month, rolling into the next year after December.
    if (cmd.walk_step) begin
      rem <= rem - REM_W'(len);
      if (month == MONTH_DEC) begin
        month <= MONTH_JAN;
        year <= year + (YEAR_W+1)'(1);
        ymod <= (ymod == CYCLE_LAST) ? '0 : ymod + YEAR_W'(1);
      end else begin
        month <= month + 4'd1;
      end
    end
  end

  // Result register; an error passes the start date through.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (bad) begin
        out_data.end_year <= start.start_year;
        out_data.end_month <= start.start_month;
        out_data.end_day <= start.start_day;
        out_data.error <= 1'b1;
      end else begin
        out_data.end_year <= year[YEAR_W-1:0];
        out_data.end_month <= month;
        out_data.end_day <= rem[DAY_W-1:0];
        out_data.error <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/gregorian_date_add_days.sv @@
// Top level of the Gregorian date adder: controller plus datapath.
// Depends on gda_pkg, gda_ctrl and gda_datapath.
//
// Adds a count of days to a Gregorian date. One item is worked at a time:
// after acceptance the year is reduced modulo 400, the lengths of the
// months before the start month are summed at one month per cycle, then
// the date is walked forward one month per cycle until the remainder fits,
// and the result register is loaded once the output register is free. An
// invalid month skips the reduction, sum and walk. A result waits in the
// output register while the next item is accepted and worked. An invalid
// month, or a result year above 16383, sets error and returns the start
// date unchanged.
`default_nettype none

module gregorian_date_add_days (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire gda_pkg::gda_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output gda_pkg::gda_out_t     out_data
);
  import gda_pkg::*;

  gda_cmd_t    cmd;
  gda_status_t status;

  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gda_datapath u_datapath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after an item was accepted");

  // A new result appears only at the end of an item's work.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  // A result without error carries a real month.
  a_month_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.error) |->
      (out_data.end_month >= MONTH_JAN && out_data.end_month <= MONTH_DEC))
    else $error("result month out of range");

endmodule

`default_nettype wire

@@ sim/gda_date_checker.sv @@
`timescale 1ns / 100ps
// Checker for the Gregorian date adder: watches both channels, predicts each result and compares.
// Depends on gda_pkg for the item types and the month codes.

module gda_date_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  gda_pkg::gda_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  gda_pkg::gda_out_t out_data,
  output int unsigned       mismatches,
  output int unsigned       pending,
  output int unsigned       dates_checked,
  output int unsigned       dates_flagged
);
  import gda_pkg::*;

  localparam int unsigned YEAR_TOP = (1 << YEAR_W) - 1;

  // Dates predicted for accepted items, oldest first.
  gda_out_t expected_dates[$];

  // Where the last month walk ended, or the start date after an error.
  logic [REM_W-1:0]  walk_rem;
  logic [MONTH_W-1:0] walk_month;
  logic [YEAR_W:0]   walk_year;

  // Gregorian rule: every 400th year, or every 4th year that is not a century.
  function automatic bit is_leap(input int unsigned year);
    return (year % 400 == 0) || ((year % 100 != 0) && (year % 4 == 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned year, input int unsigned month);
    int unsigned len;
    case (month)
      MONTH_FEB: len = is_leap(year) ? 29 : 28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  // Forms the day of the year, then walks month by month from January until the
  // remainder fits. A bad month or a year past the top passes the start date through.
  function automatic gda_out_t advance_date(input gda_in_t item);
    int unsigned year;
    int unsigned month;
    int unsigned rem;
    int unsigned len;
    bit bad;
    gda_out_t res;
    year = item.start_year;
    rem = item.start_day + item.days_to_add;
    bad = (item.start_month < MONTH_JAN) || (item.start_month > MONTH_DEC);
    if (!bad) begin
      for (month = MONTH_JAN; month < item.start_month; month++) begin
        rem += month_length(year, month);
      end
      month = MONTH_JAN;
      len = month_length(year, month);
      while (rem > len) begin
        rem -= len;
        month++;
        if (month > MONTH_DEC) begin
          month = MONTH_JAN;
          year++;
        end
        len = month_length(year, month);
      end
      if (year > YEAR_TOP) begin
        bad = 1'b1;
      end else begin
        walk_rem = rem[REM_W-1:0];
        walk_month = month[MONTH_W-1:0];
        walk_year = year[YEAR_W:0];
      end
    end
    if (bad) begin
      walk_rem = REM_W'(item.start_day);
      walk_month = item.start_month;
      walk_year = (YEAR_W+1)'(item.start_year);
    end
    res.end_year = walk_year[YEAR_W-1:0];
    res.end_month = walk_month;
    res.end_day = walk_rem[DAY_W-1:0];
    res.error = bad;
    return res;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Predict on every accepted input item and compare on every accepted result.
  always @(posedge clk) begin : watch
    gda_out_t want;
    if (rst) begin
      expected_dates.delete();
      walk_rem = '0;
      walk_month = '0;
      walk_year = '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_dates.push_back(advance_date(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          $error("result with no item outstanding: year %0d, month %0d, day %0d, error %0d",
                 out_data.end_year, out_data.end_month, out_data.end_day, out_data.error);
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          check_field("end_year", 32'(want.end_year), 32'(out_data.end_year));
          check_field("end_month", 32'(want.end_month), 32'(out_data.end_month));
          check_field("end_day", 32'(want.end_day), 32'(out_data.end_day));
          check_field("error", 32'(want.error), 32'(out_data.error));
          dates_checked++;
          if (want.error) begin
            dates_flagged++;
          end
        end
      end
    end
    pending <= $unsigned(expected_dates.size());
  end

endmodule

@@ sim/tb_gregorian_date_add_days.sv @@
`timescale 1ns / 100ps
// Testbench top for the Gregorian date adder: clock, reset, item stimulus and the verdict.
// Depends on gda_pkg, gregorian_date_add_days and gda_date_checker.

module tb_gregorian_date_add_days;
  import gda_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 540;
  localparam int unsigned HOLD_CYCLES = 4000;
  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned YEAR_TOP = (1 << YEAR_W) - 1;
  localparam int unsigned ADD_TOP = (1 << ADD_W) - 1;
  localparam logic [MONTH_W-1:0] MONTH_NONE = 4'd0;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  gda_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  gda_out_t out_data;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned dates_checked;
  int unsigned dates_flagged;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  gregorian_date_add_days dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  gda_date_checker date_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .pending       (pending),
    .dates_checked (dates_checked),
    .dates_flagged (dates_flagged)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The result side stalls at random, and once holds off for a long stretch so that
  // the block fills up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic gda_in_t make_date(input int unsigned year, input int unsigned month,
                                        input int unsigned day, input int unsigned add);
    gda_in_t item;
    item.start_year = YEAR_W'(year);
    item.start_month = MONTH_W'(month);
    item.start_day = DAY_W'(day);
    item.days_to_add = ADD_W'(add);
    return item;
  endfunction

  // Mostly valid dates with short spans; a few long spans, top years and bad months.
  function automatic gda_in_t random_date();
    gda_in_t item;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      item.start_year = YEAR_W'($urandom_range(YEAR_TOP));
    end else if (pick < 85) begin
      item.start_year = YEAR_W'($urandom_range(YEAR_TOP / 100) * 100);
    end else begin
      item.start_year = YEAR_W'($urandom_range(YEAR_TOP, YEAR_TOP - 130));
    end
    if ($urandom_range(99) < 8) begin
      pick = $urandom_range(3);
      item.start_month = (pick == 0) ? MONTH_NONE : MONTH_W'(MONTH_DEC + pick);
    end else begin
      item.start_month = MONTH_W'($urandom_range(MONTH_DEC, MONTH_JAN));
    end
    item.start_day = DAY_W'(($urandom_range(99) < 80) ? $urandom_range(28, 1) :
                                                         $urandom_range(31));
    pick = $urandom_range(99);
    if (pick < 60) begin
      item.days_to_add = ADD_W'($urandom_range(400));
    end else if (pick < 80) begin
      item.days_to_add = ADD_W'($urandom_range(4000));
    end else if (pick < 95) begin
      item.days_to_add = ADD_W'($urandom_range(ADD_TOP));
    end else begin
      item.days_to_add = ADD_W'(ADD_TOP - $urandom_range(15));
    end
    return item;
  endfunction

  // Offers one item after a random gap and holds it until it is taken.
  task automatic send_date(input gda_in_t item);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Stops offering items until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int unsigned n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Leap rule around February, year ends, field extremes and bad months.
    send_date(make_date(2000, MONTH_FEB, 28, 1));
    send_date(make_date(1900, MONTH_FEB, 28, 1));
    send_date(make_date(2024, MONTH_FEB, 28, 1));
    send_date(make_date(2400, MONTH_FEB, 31, 0));
    send_date(make_date(2023, MONTH_DEC, 31, 1));
    send_date(make_date(2100, MONTH_MAR, 1, 365));
    send_date(make_date(0, MONTH_JAN, 1, 0));
    send_date(make_date(0, MONTH_DEC, 31, ADD_TOP));
    send_date(make_date(2000, MONTH_JAN, 1, ADD_TOP));
    send_date(make_date(YEAR_TOP, MONTH_DEC, 31, 0));
    send_date(make_date(YEAR_TOP, MONTH_DEC, 31, 1));
    send_date(make_date(16300, MONTH_JAN, 1, ADD_TOP));
    send_date(make_date(1, MONTH_JAN, 0, 0));
    send_date(make_date(2021, MONTH_APR, 31, 0));
    send_date(make_date(2021, MONTH_MAR, 0, 0));
    send_date(make_date(2020, MONTH_NOV, 31, 30));
    send_date(make_date(YEAR_TOP, MONTH_NONE, 31, ADD_TOP));
    send_date(make_date(1999, MONTH_DEC + 1, 15, 100));
    send_date(make_date(0, MONTH_DEC + 2, 0, 0));
    send_date(make_date(YEAR_TOP, MONTH_DEC + 3, 31, ADD_TOP));
    wait_drained();

    // Random items in three idling patterns; the first starts with the long hold-off.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0) begin
        tx_idle_pct = 37;
        rx_idle_pct = 46;
        hold_go <= 1'b1;
      end else if (n == RANDOM_ITEMS / 3) begin
        wait_drained();
        tx_idle_pct = 46;
        rx_idle_pct = 37;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_date(random_date());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d date items, including leap days, century years, overlong days,",
             items_sent);
    $display("bad months and year overflow; %0d results compared, %0d of them flagged.",
             dates_checked, dates_flagged);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ gregorian_date_add_days.f @@
hdl/gda_pkg.sv
hdl/gda_ctrl.sv
hdl/gda_datapath.sv
hdl/gregorian_date_add_days.sv
sim/gda_date_checker.sv
sim/tb_gregorian_date_add_days.sv
